// ===== hdl/acrms_pkg.sv =====
package acrms_pkg;

  localparam int SAMPLE_W   = 10;
  localparam int RMS_W      = 10;
  localparam int SUM_W      = 32;
  localparam int COUNT_W    = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_START_DELAY = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_STOP_DELAY  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_CYCLES      = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_SAMPLES = 3'd4;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int DIV_STEPS  = SUM_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  localparam int ROOT_TABLE_DEPTH = 256;

  // root range limits
  localparam logic [15:0] ROOT_LIM_A = 16'h4000;
  localparam logic [15:0] ROOT_LIM_B = 16'h1000;
  localparam logic [15:0] ROOT_LIM_C = 16'h0400;
  localparam logic [15:0] ROOT_LIM_D = 16'h0100;

  typedef struct packed {
    logic               fail;
    logic [SUM_W-1:0]   sum;
    logic [COUNT_W-1:0] count;
  } acrms_job_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_DIV,
    B_LOOK,
    B_TRIM,
    B_OUT
  } acrms_state_t;

  localparam logic [7:0] ROOT_TAB [ROOT_TABLE_DEPTH] = '{
    8'd0,   8'd16,  8'd22,  8'd27,  8'd32,  8'd35,  8'd39,  8'd42,
    8'd45,  8'd48,  8'd50,  8'd53,  8'd55,  8'd57,  8'd59,  8'd61,
    8'd64,  8'd65,  8'd67,  8'd69,  8'd71,  8'd73,  8'd75,  8'd76,
    8'd78,  8'd80,  8'd81,  8'd83,  8'd84,  8'd86,  8'd87,  8'd89,
    8'd90,  8'd91,  8'd93,  8'd94,  8'd96,  8'd97,  8'd98,  8'd99,
    8'd101, 8'd102, 8'd103, 8'd104, 8'd106, 8'd107, 8'd108, 8'd109,
    8'd110, 8'd112, 8'd113, 8'd114, 8'd115, 8'd116, 8'd117, 8'd118,
    8'd119, 8'd120, 8'd121, 8'd122, 8'd123, 8'd124, 8'd125, 8'd126,
    8'd128, 8'd128, 8'd129, 8'd130, 8'd131, 8'd132, 8'd133, 8'd134,
    8'd135, 8'd136, 8'd137, 8'd138, 8'd139, 8'd140, 8'd141, 8'd142,
    8'd143, 8'd144, 8'd144, 8'd145, 8'd146, 8'd147, 8'd148, 8'd149,
    8'd150, 8'd150, 8'd151, 8'd152, 8'd153, 8'd154, 8'd155, 8'd155,
    8'd156, 8'd157, 8'd158, 8'd159, 8'd160, 8'd160, 8'd161, 8'd162,
    8'd163, 8'd163, 8'd164, 8'd165, 8'd166, 8'd167, 8'd167, 8'd168,
    8'd169, 8'd170, 8'd170, 8'd171, 8'd172, 8'd173, 8'd173, 8'd174,
    8'd175, 8'd176, 8'd176, 8'd177, 8'd178, 8'd178, 8'd179, 8'd180,
    8'd181, 8'd181, 8'd182, 8'd183, 8'd183, 8'd184, 8'd185, 8'd185,
    8'd186, 8'd187, 8'd187, 8'd188, 8'd189, 8'd189, 8'd190, 8'd191,
    8'd192, 8'd192, 8'd193, 8'd193, 8'd194, 8'd195, 8'd195, 8'd196,
    8'd197, 8'd197, 8'd198, 8'd199, 8'd199, 8'd200, 8'd201, 8'd201,
    8'd202, 8'd203, 8'd203, 8'd204, 8'd204, 8'd205, 8'd206, 8'd206,
    8'd207, 8'd208, 8'd208, 8'd209, 8'd209, 8'd210, 8'd211, 8'd211,
    8'd212, 8'd212, 8'd213, 8'd214, 8'd214, 8'd215, 8'd215, 8'd216,
    8'd217, 8'd217, 8'd218, 8'd218, 8'd219, 8'd219, 8'd220, 8'd221,
    8'd221, 8'd222, 8'd222, 8'd223, 8'd224, 8'd224, 8'd225, 8'd225,
    8'd226, 8'd226, 8'd227, 8'd227, 8'd228, 8'd229, 8'd229, 8'd230,
    8'd230, 8'd231, 8'd231, 8'd232, 8'd232, 8'd233, 8'd234, 8'd234,
    8'd235, 8'd235, 8'd236, 8'd236, 8'd237, 8'd237, 8'd238, 8'd238,
    8'd239, 8'd240, 8'd240, 8'd241, 8'd241, 8'd242, 8'd242, 8'd243,
    8'd243, 8'd244, 8'd244, 8'd245, 8'd245, 8'd246, 8'd246, 8'd247,
    8'd247, 8'd248, 8'd248, 8'd249, 8'd249, 8'd250, 8'd250, 8'd251,
    8'd251, 8'd252, 8'd252, 8'd253, 8'd253, 8'd254, 8'd254, 8'd255
  };

endpackage

// ===== hdl/acrms_front.sv =====
module acrms_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [acrms_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [acrms_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                               accept,
  input  logic [acrms_pkg::SAMPLE_W-1:0]     sample,
  output logic                               push,
  output acrms_pkg::acrms_job_t              push_job
);
  import acrms_pkg::*;

  logic [SAMPLE_W-1:0] crossing_threshold;
  logic [7:0]          start_delay;
  logic [7:0]          stop_delay;
  logic [7:0]          cycles_per_window;
  logic [COUNT_W-1:0]  max_window_samples;

  logic               high_phase, high_phase_next;
  logic               stop_seen, stop_seen_next;
  logic [7:0]         high_counter, high_counter_next;
  logic [7:0]         low_counter, low_counter_next;
  logic [7:0]         half_left, half_left_next;
  logic [COUNT_W-1:0] sample_count, sample_count_next;
  logic [SUM_W-1:0]   square_sum, square_sum_next;

  logic       close, close_dc;
  logic [7:0] q;
  logic [15:0] sq;

  assign q  = sample[SAMPLE_W-1:2];
  assign sq = {8'd0, q} * {8'd0, q};

  always_ff @(posedge clk) begin
    if (rst) begin
      crossing_threshold <= 10'd512;
      start_delay        <= 8'd4;
      stop_delay         <= 8'd4;
      cycles_per_window  <= 8'd4;
      max_window_samples <= 16'd2000;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_THRESHOLD:   crossing_threshold <= cfg_data[SAMPLE_W-1:0];
        REG_START_DELAY: start_delay        <= cfg_data[7:0];
        REG_STOP_DELAY:  stop_delay         <= cfg_data[7:0];
        REG_CYCLES:      cycles_per_window  <= cfg_data[7:0];
        REG_MAX_SAMPLES: max_window_samples <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    high_phase_next   = high_phase;
    stop_seen_next    = stop_seen;
    high_counter_next = high_counter;
    low_counter_next  = low_counter;
    half_left_next    = half_left;
    close             = 1'b0;
    close_dc          = 1'b0;

    if (sample > crossing_threshold) begin
      if (!high_phase) begin
        if (high_counter != 8'hFF) high_counter_next = high_counter + 8'd1;
        if (high_counter_next >= start_delay) begin
          high_phase_next  = 1'b1;
          low_counter_next = 8'd0;
          if (stop_seen) begin
            stop_seen_next = 1'b0;
            if (half_left != 8'd0) half_left_next = half_left - 8'd1;
            if (half_left_next == 8'd0) begin
              close          = 1'b1;
              half_left_next = cycles_per_window;
            end
          end
        end
      end
    end else if (high_phase) begin
      if (low_counter != 8'hFF) low_counter_next = low_counter + 8'd1;
      if (low_counter_next >= stop_delay) begin
        high_phase_next   = 1'b0;
        stop_seen_next    = 1'b1;
        high_counter_next = 8'd0;
      end
    end

    // DC: no stop pending and count at limit closes a failed window
    if (!close && !stop_seen_next && sample_count >= max_window_samples) begin
      close            = 1'b1;
      close_dc         = 1'b1;
      high_phase_next  = 1'b1;
      low_counter_next = 8'd0;
      stop_seen_next   = 1'b0;
      half_left_next   = cycles_per_window;
    end

    // closing sample opens the next window
    square_sum_next = (close ? '0 : square_sum) + {16'd0, sq};
    if (close)
      sample_count_next = {{(COUNT_W-1){1'b0}}, 1'b1};
    else if (sample_count != {COUNT_W{1'b1}})
      sample_count_next = sample_count + {{(COUNT_W-1){1'b0}}, 1'b1};
    else
      sample_count_next = sample_count;
  end

  assign push           = accept && close;
  assign push_job.fail  = close_dc;
  assign push_job.sum   = square_sum;
  assign push_job.count = sample_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      high_phase   <= 1'b0;
      stop_seen    <= 1'b0;
      high_counter <= 8'd0;
      low_counter  <= 8'd0;
      half_left    <= 8'd0;
      sample_count <= '0;
      square_sum   <= '0;
    end else if (accept) begin
      high_phase   <= high_phase_next;
      stop_seen    <= stop_seen_next;
      high_counter <= high_counter_next;
      low_counter  <= low_counter_next;
      half_left    <= half_left_next;
      sample_count <= sample_count_next;
      square_sum   <= square_sum_next;
    end
  end

endmodule

// ===== hdl/acrms_queue.sv =====
module acrms_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  acrms_pkg::acrms_job_t  push_job,
  output logic                   full,
  input  logic                   pop,
  output logic                   pop_valid,
  output acrms_pkg::acrms_job_t  pop_job
);
  import acrms_pkg::*;

  acrms_job_t        entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] fill;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    logic [QPTR_W-1:0] r;
    r = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
    return r;
  endfunction

  assign full      = (fill == QCNT_W'(QUEUE_DEPTH));
  assign pop_valid = (fill != '0);
  assign pop_job   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= ptr_inc(wr_ptr);
      if (pop)  rd_ptr <= ptr_inc(rd_ptr);
      case ({push, pop})
        2'b10:   fill <= fill + QCNT_W'(1);
        2'b01:   fill <= fill - QCNT_W'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== hdl/acrms_back.sv =====
module acrms_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          job_valid,
  input  acrms_pkg::acrms_job_t         job,
  output logic                          job_pop,
  output logic                          rms_valid,
  input  logic                          rms_stall,
  output logic [acrms_pkg::RMS_W-1:0]   rms_value,
  output logic                          rms_pass
);
  import acrms_pkg::*;

  acrms_state_t state, state_next;

  logic [SUM_W-1:0]     num, num_next;
  logic [COUNT_W-1:0]   divisor, divisor_next;
  logic [COUNT_W-1:0]   rem, rem_next;
  logic [DIV_CNT_W-1:0] step, step_next;
  logic [15:0]          x, x_next;
  logic [8:0]           root, root_next;
  logic                 direct, direct_next;
  logic [RMS_W-1:0]     val, val_next;
  logic                 pass, pass_next;
  logic                 rms_valid_next;
  logic [RMS_W-1:0]     rms_value_next;
  logic                 rms_pass_next;

  logic [COUNT_W:0] trial;
  logic [7:0]       tab_idx, tab_val;
  logic [17:0]      root_sq;
  logic [8:0]       root_fix;

  assign tab_val = ROOT_TAB[tab_idx];
  assign root_sq = {9'd0, root} * {9'd0, root};
  assign trial   = {rem, num[SUM_W-1]};

  always_comb begin
    state_next     = state;
    num_next       = num;
    divisor_next   = divisor;
    rem_next       = rem;
    step_next      = step;
    x_next         = x;
    root_next      = root;
    direct_next    = direct;
    val_next       = val;
    pass_next      = pass;
    rms_valid_next = rms_valid && rms_stall;
    rms_value_next = rms_value;
    rms_pass_next  = rms_pass;
    job_pop        = 1'b0;
    tab_idx        = x[9:2];
    root_fix       = root;

    case (state)
      B_IDLE: begin
        if (job_valid) begin
          job_pop      = 1'b1;
          num_next     = job.sum;
          divisor_next = job.count;
          rem_next     = '0;
          step_next    = DIV_CNT_W'(DIV_STEPS - 1);
          pass_next    = !job.fail;
          val_next     = '0;
          if (job.fail || job.count == '0) state_next = B_OUT;
          else state_next = B_DIV;
        end
      end
      // restoring divide, one quotient bit per cycle
      B_DIV: begin
        if (trial >= {1'b0, divisor}) begin
          rem_next = COUNT_W'(trial - {1'b0, divisor});
          num_next = {num[SUM_W-2:0], 1'b1};
        end else begin
          rem_next = trial[COUNT_W-1:0];
          num_next = {num[SUM_W-2:0], 1'b0};
        end
        step_next = step - DIV_CNT_W'(1);
        if (step == '0) begin
          x_next     = num_next[15:0];
          state_next = B_LOOK;
        end
      end
      B_LOOK: begin
        direct_next = 1'b0;
        if (x < ROOT_LIM_D) begin
          tab_idx     = x[7:0];
          root_next   = {5'd0, tab_val[7:4]};
          direct_next = 1'b1;
        end else if (x >= ROOT_LIM_A) begin
          tab_idx   = x[15:8];
          root_next = {1'b0, tab_val} + 9'd1;
        end else if (x >= ROOT_LIM_B) begin
          tab_idx   = x[13:6];
          root_next = {2'd0, tab_val[7:1]} + 9'd1;
        end else if (x >= ROOT_LIM_C) begin
          tab_idx   = x[11:4];
          root_next = {3'd0, tab_val[7:2]} + 9'd1;
        end else begin
          tab_idx   = x[9:2];
          root_next = {4'd0, tab_val[7:3]} + 9'd1;
        end
        state_next = B_TRIM;
      end
      B_TRIM: begin
        if (!direct && root_sq > {2'd0, x}) root_fix = root - 9'd1;
        val_next   = {root_fix[7:0], 2'b00};
        state_next = B_OUT;
      end
      B_OUT: begin
        if (!rms_valid || !rms_stall) begin
          rms_valid_next = 1'b1;
          rms_value_next = val;
          rms_pass_next  = pass;
          state_next     = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      rms_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rms_valid <= rms_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    num       <= num_next;
    divisor   <= divisor_next;
    rem       <= rem_next;
    step      <= step_next;
    x         <= x_next;
    root      <= root_next;
    direct    <= direct_next;
    val       <= val_next;
    pass      <= pass_next;
    rms_value <= rms_value_next;
    rms_pass  <= rms_pass_next;
  end

endmodule

// ===== hdl/ac_voltage_rms_meter_unit.sv =====
// AC RMS meter: samples are taken one per cycle while the job queue has room.
// A window result goes from its closing sample through queue pop, 32-step divider,
// table lookup, root trim and output register (DC or empty window: pop, then output).
// The back end takes a window only when idle; the 2-entry queue absorbs bursts.
// Reset (rst, synchronous, active high) clears all window state and the queue and
// loads the register defaults.
module ac_voltage_rms_meter_unit (
  input  logic                              clk,
  input  logic                              rst,
  // configuration write port
  input  logic                              cfg_write,
  input  logic [acrms_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [acrms_pkg::CFG_DATA_W-1:0]  cfg_data,
  // sample channel
  input  logic                              sample_valid,
  output logic                              sample_stall,
  input  logic [acrms_pkg::SAMPLE_W-1:0]    sample,
  // result channel
  output logic                              rms_valid,
  input  logic                              rms_stall,
  output logic [acrms_pkg::RMS_W-1:0]       rms_value,
  output logic                              rms_pass
);
  import acrms_pkg::*;

  logic       accept;
  logic       q_push, q_full, q_pop, q_valid;
  acrms_job_t q_in, q_out;

  // front stalls only when the job queue is full
  assign sample_stall = q_full;
  assign accept       = sample_valid && !sample_stall;

  // front: crossing debounce, half-cycle count, square sum, window close
  acrms_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .sample    (sample),
    .push      (q_push),
    .push_job  (q_in)
  );

  // closed windows waiting for the divider
  acrms_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_job  (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_job   (q_out)
  );

  // back: mean square divide, table root, result register
  acrms_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (q_valid),
    .job       (q_out),
    .job_pop   (q_pop),
    .rms_valid (rms_valid),
    .rms_stall (rms_stall),
    .rms_value (rms_value),
    .rms_pass  (rms_pass)
  );

  // a closing window never lands on a full queue
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("window pushed into full queue");

  // back end only takes jobs that exist
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("job popped from empty queue");

  // a DC window always reports zero
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (rms_valid && !rms_pass) |-> (rms_value == '0))
    else $error("failed window with nonzero value");

endmodule

// ===== test/ac_voltage_rms_meter_unit_test.sv =====
module ac_voltage_rms_meter_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import acrms_pkg::*;

  // Generous watchdog. Even if every sample closed a window, under the slowest
  // idle/stall mix plus the long output hold, a full run stays far below this.
  localparam int CYCLE_LIMIT    = 400_000;
  localparam int SETTLE_CYCLES  = 48;
  localparam int ITEMS_PER_MIX  = 45;
  localparam int HOLD_CYCLES    = 400;
  localparam int MAX_REPORTS    = 200;

  localparam logic [CFG_INDEX_W-1:0] REG_ORDER [5] = '{
    REG_THRESHOLD, REG_START_DELAY, REG_STOP_DELAY, REG_CYCLES, REG_MAX_SAMPLES
  };

  typedef struct packed {
    logic [RMS_W-1:0] value;
    logic             pass;
  } reading_t;

  // DUT-facing signals; the ones the bench drives are known from time zero
  logic                   clk          = 1'b0;
  logic                   rst          = 1'b1;
  logic                   cfg_write    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index    = '0;
  logic [CFG_DATA_W-1:0]  cfg_data     = '0;
  logic                   sample_valid = 1'b0;
  logic                   sample_stall;
  logic [SAMPLE_W-1:0]    sample       = '0;
  logic                   rms_valid;
  logic                   rms_stall    = 1'b0;
  logic [RMS_W-1:0]       rms_value;
  logic                   rms_pass;

  // Meter model: register copies (reset defaults) and window state
  logic [SAMPLE_W-1:0] cfg_threshold   = 10'd512;
  logic [7:0]          cfg_start_delay = 8'd4;
  logic [7:0]          cfg_stop_delay  = 8'd4;
  logic [7:0]          cfg_halves      = 8'd4;
  logic [COUNT_W-1:0]  cfg_max_count   = 16'd2000;

  logic               in_high      = 1'b0;
  logic               stop_pending = 1'b0;
  logic               dc_flag      = 1'b0;
  logic [7:0]         high_run     = '0;
  logic [7:0]         low_run      = '0;
  logic [7:0]         halves_left  = '0;
  logic [COUNT_W-1:0] window_count = '0;
  logic [SUM_W-1:0]   window_energy = '0;

  reading_t pending_readings[$];
  reading_t oldest;

  // Stimulus knobs
  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;
  int hold_request       = 0;
  int hold_left          = 0;
  int wave_span          = 1023;

  // Bookkeeping
  int cycle_count      = 0;
  int fail_count       = 0;
  int items_sent       = 0;
  int ac_readings      = 0;
  int dc_readings      = 0;
  int settings_applied = 0;

  ac_voltage_rms_meter_unit dut (
    .clk,
    .rst,
    .cfg_write,
    .cfg_index,
    .cfg_data,
    .sample_valid,
    .sample_stall,
    .sample,
    .rms_valid,
    .rms_stall,
    .rms_value,
    .rms_pass
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("%0t: timeout, %0d readings still outstanding", $time, pending_readings.size());
    $display("== FAIL ==");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Meter model
  // ---------------------------------------------------------------------------

  // Coarse root from the 256-entry table, picked by the magnitude range of x,
  // then trimmed down by one when the +1 rounding overshoots.
  function automatic logic [7:0] approx_root(input logic [15:0] x);
    int r;
    if (x < ROOT_LIM_D) return ROOT_TAB[x[7:0]] >> 4;
    if (x >= ROOT_LIM_A)      r = ROOT_TAB[x[15:8]] + 1;
    else if (x >= ROOT_LIM_B) r = (ROOT_TAB[x[13:6]] >> 1) + 1;
    else if (x >= ROOT_LIM_C) r = (ROOT_TAB[x[11:4]] >> 2) + 1;
    else                      r = (ROOT_TAB[x[9:2]] >> 3) + 1;
    if (r * r > int'(x)) r--;
    return r[7:0];
  endfunction

  // Confirmed start of a high half cycle (or a forced one on DC). Returns 1
  // when this closes the window and queues the reading it produces.
  function automatic bit begin_half();
    logic [SUM_W-1:0] mean;
    reading_t         rd;
    in_high = 1'b1;
    low_run = '0;
    if (!stop_pending) return 1'b0;
    stop_pending = 1'b0;
    if (halves_left != 0) halves_left--;
    if (halves_left != 0) return 1'b0;
    if (dc_flag) begin
      rd = '{value: '0, pass: 1'b0};
    end else begin
      rd = '{value: '0, pass: 1'b1};
      if (window_count != 0) begin
        mean = window_energy / {16'd0, window_count};
        rd.value = {approx_root(mean[15:0]), 2'b00};
      end
    end
    pending_readings.push_back(rd);
    dc_flag       = 1'b0;
    window_count  = '0;
    window_energy = '0;
    halves_left   = cfg_halves;
    return 1'b1;
  endfunction

  task automatic meter_sample(input logic [SAMPLE_W-1:0] s);
    bit         closed;
    logic [7:0] q;
    closed = 1'b0;
    if (s > cfg_threshold) begin
      if (!in_high) begin
        if (high_run != 8'hFF) high_run++;
        if (high_run >= cfg_start_delay) closed = begin_half();
      end
    end else if (in_high) begin
      if (low_run != 8'hFF) low_run++;
      if (low_run >= cfg_stop_delay) begin
        in_high      = 1'b0;
        stop_pending = 1'b1;
        high_run     = '0;
      end
    end
    // no stop in sight for too long: treat the input as DC
    if (!closed && !stop_pending && window_count >= cfg_max_count) begin
      dc_flag      = 1'b1;
      halves_left  = 8'd1;
      stop_pending = 1'b1;
      closed       = begin_half();
    end
    q = s[9:2];
    window_energy = window_energy + 32'(q) * 32'(q);
    if (window_count != 16'hFFFF) window_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Reading check: each accepted reading against the oldest expected one
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && rms_valid && !rms_stall) begin
      if (pending_readings.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("%0t: unexpected reading, expected none, actual value %0d pass %0d",
                   $time, rms_value, rms_pass);
      end else begin
        oldest = pending_readings.pop_front();
        if (rms_value !== oldest.value) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("%0t: rms_value expected %0d actual %0d", $time, oldest.value, rms_value);
        end
        if (rms_pass !== oldest.pass) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("%0t: rms_pass expected %0d actual %0d", $time, oldest.pass, rms_pass);
        end
        if (oldest.pass) ac_readings++;
        else dc_readings++;
      end
    end
  end

  // Output side: random stall, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      rms_stall <= 1'b1;
    end else begin
      rms_stall <= ($urandom_range(99) < receiver_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Shared stimulus tasks
  // ---------------------------------------------------------------------------

  // One sample item: optional idle gap, then hold it until the meter takes it.
  task automatic send_sample(input logic [SAMPLE_W-1:0] s);
    while ($urandom_range(99) < sender_idle_pct) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample       <= s;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    meter_sample(s);
    items_sent++;
  endtask

  // Stop sending and wait until every reading is back, plus the pipeline tail.
  task automatic settle();
    sample_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure_meter(input logic [9:0] thr, input logic [7:0] t_start,
                                 input logic [7:0] t_stop, input logic [7:0] halves,
                                 input logic [15:0] max_count);
    logic [CFG_DATA_W-1:0] values [5];
    values[0] = {6'd0, thr};
    values[1] = {8'd0, t_start};
    values[2] = {8'd0, t_stop};
    values[3] = {8'd0, halves};
    values[4] = max_count;
    settle();
    for (int i = 0; i < 5; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= REG_ORDER[i];
      cfg_data  <= values[i];
      @(posedge clk);
    end
    cfg_write <= 1'b0;
    cfg_threshold   = thr;
    cfg_start_delay = t_start;
    cfg_stop_delay  = t_stop;
    cfg_halves      = halves;
    cfg_max_count   = max_count;
    settings_applied++;
  endtask

  function automatic logic [SAMPLE_W-1:0] high_level();
    if (cfg_threshold == 10'd1023) return 10'd1023;
    if (cfg_threshold < wave_span)
      return SAMPLE_W'($urandom_range(wave_span, cfg_threshold + 1));
    return SAMPLE_W'($urandom_range(1023, cfg_threshold + 1));
  endfunction

  function automatic logic [SAMPLE_W-1:0] low_level();
    return SAMPLE_W'($urandom_range(cfg_threshold, 0));
  endfunction

  // Mostly clean half cycles of random length and level; the rest is noise,
  // lone spikes that should not survive the debounce, and flat DC stretches.
  task automatic drive_waveform(input int quota);
    int                  done;
    int                  kind;
    int                  len;
    logic [SAMPLE_W-1:0] flat;
    done = 0;
    while (done < quota) begin
      kind = $urandom_range(9);
      if (kind < 7) begin
        len = $urandom_range(8, 1);
        repeat (len) send_sample(high_level());
        done += len;
        len = $urandom_range(8, 1);
        repeat (len) send_sample(low_level());
        done += len;
      end else if (kind == 7) begin
        len = $urandom_range(6, 1);
        repeat (len) send_sample(SAMPLE_W'($urandom_range(1023)));
        done += len;
      end else if (kind == 8) begin
        send_sample(high_level());
        done++;
      end else begin
        flat = SAMPLE_W'($urandom_range(1023));
        len  = $urandom_range(40, 5);
        repeat (len) send_sample(flat);
        done += len;
      end
    end
  endtask

  task automatic randomize_meter();
    logic [9:0]  thr;
    logic [7:0]  t_start;
    logic [7:0]  t_stop;
    logic [7:0]  halves;
    logic [15:0] max_count;
    int          pick;
    pick = $urandom_range(3);
    wave_span = (pick == 0) ? 63 : (pick == 1) ? 255 : (pick == 2) ? 511 : 1023;
    pick = $urandom_range(9);
    if (pick == 0)      thr = 10'd0;
    else if (pick == 1) thr = 10'd1023;
    else                thr = 10'($urandom_range(wave_span - 1));
    t_start   = 8'(($urandom_range(9) == 0) ? $urandom_range(255, 5) : $urandom_range(4, 1));
    t_stop    = 8'(($urandom_range(9) == 0) ? $urandom_range(255, 5) : $urandom_range(4, 1));
    halves    = 8'($urandom_range(4, 1));
    max_count = 16'(($urandom_range(2) == 0) ? $urandom_range(60, 1)
                                             : $urandom_range(2000, 100));
    configure_meter(thr, t_start, t_stop, halves, max_count);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Register defaults straight out of reset: start, confirmed stop, start.
  task automatic test_reset_defaults();
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    repeat (4) send_sample(10'd1023);
    repeat (4) send_sample(10'd0);
    repeat (4) send_sample(10'd1023);
  endtask

  // Field extremes and values right at the threshold; then tiny amplitudes
  // so the mean square lands in the lowest root range.
  task automatic test_directed_extremes();
    logic [SAMPLE_W-1:0] burst [10] = '{
      10'd0, 10'd1023, 10'd0, 10'd1023, 10'd512, 10'd513, 10'd0, 10'd1022, 10'd1, 10'd1023
    };
    logic [SAMPLE_W-1:0] faint [6] = '{10'd0, 10'd63, 10'd0, 10'd60, 10'd8, 10'd30};
    configure_meter(10'd512, 8'd1, 8'd1, 8'd1, 16'd2000);
    foreach (burst[i]) send_sample(burst[i]);
    configure_meter(10'd20, 8'd1, 8'd1, 8'd1, 16'd2000);
    foreach (faint[i]) send_sample(faint[i]);
  endtask

  // Flat high input never confirms a stop, so the count limit forces DC windows.
  task automatic test_dc_window();
    configure_meter(10'd512, 8'd3, 8'd3, 8'd2, 16'd8);
    repeat (16) send_sample(10'd900);
    repeat (8) send_sample(10'd50);
    // smallest nonzero limit, threshold at its floor
    configure_meter(10'd0, 8'd3, 8'd3, 8'd2, 16'd1);
    repeat (6) send_sample(10'd700);
  endtask

  // Zero delays confirm at once, zero half cycles close on every start,
  // zero count limit declares DC whenever no stop is pending.
  task automatic test_zero_registers();
    configure_meter(10'd300, 8'd0, 8'd0, 8'd0, 16'd0);
    repeat (12) send_sample(SAMPLE_W'($urandom_range(1023)));
  endtask

  // Longest debounce on both edges; a short start delay then closes the window.
  task automatic test_slow_registers();
    configure_meter(10'd512, 8'd255, 8'd255, 8'd1, 16'd65535);
    repeat (256) send_sample(10'd1000);
    repeat (256) send_sample(10'd10);
    configure_meter(10'd512, 8'd1, 8'd255, 8'd1, 16'd65535);
    send_sample(10'd1000);
  endtask

  // Output held off for a long stretch while a window closes every two
  // samples: the job queue fills and the sample input has to stall.
  task automatic test_output_hold();
    configure_meter(10'd500, 8'd1, 8'd1, 8'd1, 16'd65535);
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    hold_request       = HOLD_CYCLES;
    repeat (60) begin
      send_sample(10'd900);
      send_sample(10'd100);
    end
  endtask

  // Random settings under each idle/stall mix.
  task automatic test_random_windows();
    int idle_mix  [4] = '{0, 46, 0, 33};
    int stall_mix [4] = '{0, 0, 46, 33};
    for (int m = 0; m < 4; m++) begin
      for (int k = 0; k < 3; k++) begin
        randomize_meter();
        sender_idle_pct    = idle_mix[m];
        receiver_stall_pct = stall_mix[m];
        drive_waveform(ITEMS_PER_MIX);
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_directed_extremes();
    test_dc_window();
    test_zero_registers();
    test_slow_registers();
    test_output_hold();
    test_random_windows();
    settle();

    $display("Sent %0d samples across %0d register settings; checked %0d AC and %0d DC readings.",
             items_sent, settings_applied, ac_readings, dc_readings);
    $display("Runs included forced DC windows, zero registers, long debounce and output hold.");
    if (fail_count == 0 && pending_readings.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== ac_voltage_rms_meter_unit.f =====
hdl/acrms_pkg.sv
hdl/acrms_front.sv
hdl/acrms_queue.sv
hdl/acrms_back.sv
hdl/ac_voltage_rms_meter_unit.sv
test/ac_voltage_rms_meter_unit_test.sv
